// File: rtl/ibanm97_pkg.sv
// Types and constants shared by the IBAN mod 97 checker.
// Holds the item structs, the character classes and the fold arithmetic.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ibanm97_pkg;

	localparam int unsigned MOD_BASE    = 97;
	localparam int unsigned LETTER_BASE = 55;
	localparam int unsigned HEAD_LEN    = 4;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [5:0] COUNT_MAX        = 6'd63;
	localparam logic [5:0] MIN_LENGTH_RESET = 6'd15;
	localparam logic [5:0] HEAD_COUNT       = 6'(HEAD_LEN);

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} req_t;

	typedef struct packed {
		logic iban_valid;
		logic too_short;
		logic bad_char;
	} rsp_t;

	typedef enum logic [1:0] {
		KIND_KEPT = 2'd0,
		KIND_SKIP = 2'd1,
		KIND_BAD  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [5:0] value;
		logic       last;
	} item_t;

	// fold one value into the remainder: digits scale by 10, letters by 100 (= 3 mod 97)
	function automatic logic [6:0] fold_mod(input logic [6:0] rem, input logic [5:0] v);
		logic [9:0] x;
		logic [9:0] step;
		if (v < 6'd10) begin
			x = {rem, 3'b000} + 10'({rem, 1'b0}) + 10'(v);
		end else begin
			x = 10'({rem, 1'b0}) + 10'(rem) + 10'(v);
		end
		for (int k = 3; k >= 0; k--) begin
			step = 10'(MOD_BASE) << k;
			if (x >= step) begin
				x = x - step;
			end
		end
		return x[6:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/ibanm97_front.sv
// Front end of the IBAN mod 97 checker: classifies one input word.
// Maps a character to its value and class for the queue.
// Depends on ibanm97_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ibanm97_front (
	input  var ibanm97_pkg::req_t  req,
	output var ibanm97_pkg::item_t item
);

	logic [7:0] c;

	assign c = req.char_code;

	always_comb begin
		item.last  = req.last;
		item.value = '0;
		item.kind  = ibanm97_pkg::KIND_BAD;
		priority if (c >= 8'h30 && c <= 8'h39) begin
			item.kind  = ibanm97_pkg::KIND_KEPT;
			item.value = 6'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h5A) begin
			item.kind  = ibanm97_pkg::KIND_KEPT;
			item.value = 6'(c - 8'(ibanm97_pkg::LETTER_BASE));
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			item.kind  = ibanm97_pkg::KIND_KEPT;
			item.value = 6'(c - 8'h57);
		end else if (c == 8'h2D || c == 8'h20) begin
			item.kind  = ibanm97_pkg::KIND_SKIP;
		end else begin
			item.kind  = ibanm97_pkg::KIND_BAD;
		end
	end

endmodule

`default_nettype wire

// File: rtl/ibanm97_queue.sv
// Short first-word-fall-through queue between front and back end.
// Holds classified words so each side can stall on its own.
// Depends on ibanm97_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ibanm97_queue (
	input  var logic                clk,
	input  var logic                arst_n,
	input  var logic                wr_valid,
	output var logic                wr_ready,
	input  var ibanm97_pkg::item_t  wr_item,
	output var logic                rd_valid,
	input  var logic                rd_ready,
	output var ibanm97_pkg::item_t  rd_item
);

	localparam int unsigned Depth = ibanm97_pkg::QUEUE_DEPTH;
	localparam int unsigned PtrW  = $clog2(Depth);

	ibanm97_pkg::item_t  mem_q [Depth];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [PtrW:0]       count_q;
	logic                push;
	logic                pop;

	assign wr_ready = (count_q != (PtrW+1)'(Depth));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/ibanm97_back.sv
// Back end of the IBAN mod 97 checker: folds kept characters, buffers the head,
// folds the head serially at the end and drives the result register.
// Depends on ibanm97_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ibanm97_back #(
	parameter int unsigned MAX_KEPT = 32
) (
	input  var logic                clk,
	input  var logic                arst_n,
	input  var logic [5:0]          min_length,
	input  var logic                item_valid,
	output var logic                item_ready,
	input  var ibanm97_pkg::item_t  item,
	output var logic                rsp_valid,
	input  var logic                rsp_ready,
	output var ibanm97_pkg::rsp_t   rsp
);

	localparam logic [5:0] MaxKept = 6'(MAX_KEPT);

	typedef enum logic [1:0] {
		ST_RUN,
		ST_FOLD,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [6:0]         rem_q;
	logic [5:0]         kept_count_q;
	logic               error_seen_q;
	logic [1:0]         fold_idx_q;
	logic [5:0]         head_q [ibanm97_pkg::HEAD_LEN];
	logic               rsp_valid_q;
	ibanm97_pkg::rsp_t  rsp_q;

	logic               is_kept;
	logic               in_head;
	logic [5:0]         count_next;
	logic               out_load;
	ibanm97_pkg::rsp_t  result;

	assign item_ready = (state_q == ST_RUN);
	assign is_kept    = (item.kind == ibanm97_pkg::KIND_KEPT);
	assign in_head    = (kept_count_q < ibanm97_pkg::HEAD_COUNT);
	assign count_next = (is_kept && kept_count_q != ibanm97_pkg::COUNT_MAX) ?
		kept_count_q + 6'd1 : kept_count_q;
	assign out_load   = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		result.too_short  = (kept_count_q < ibanm97_pkg::HEAD_COUNT) ||
			(kept_count_q < min_length);
		result.bad_char   = error_seen_q;
		result.iban_valid = !result.too_short && !error_seen_q &&
			(kept_count_q <= MaxKept) && (rem_q == 7'd1);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && item_valid && is_kept && in_head) begin
			head_q[kept_count_q[1:0]] <= item.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RUN;
			rem_q        <= '0;
			kept_count_q <= '0;
			error_seen_q <= 1'b0;
			fold_idx_q   <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready && !out_load) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_RUN: begin
					if (item_valid) begin
						unique case (item.kind)
							ibanm97_pkg::KIND_KEPT: begin
								if (!in_head) begin
									rem_q <= ibanm97_pkg::fold_mod(rem_q, item.value);
								end
								kept_count_q <= count_next;
							end
							ibanm97_pkg::KIND_BAD: error_seen_q <= 1'b1;
							default: ;
						endcase
						if (item.last) begin
							state_q <= (count_next >= ibanm97_pkg::HEAD_COUNT) ?
								ST_FOLD : ST_DONE;
						end
					end
				end
				ST_FOLD: begin
					rem_q      <= ibanm97_pkg::fold_mod(rem_q, head_q[fold_idx_q]);
					fold_idx_q <= fold_idx_q + 2'd1;
					if (fold_idx_q == 2'(ibanm97_pkg::HEAD_LEN - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						rsp_q        <= result;
						rsp_valid_q  <= 1'b1;
						rem_q        <= '0;
						kept_count_q <= '0;
						error_seen_q <= 1'b0;
						state_q      <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q < 7'(ibanm97_pkg::MOD_BASE))
		else $error("remainder out of range");

	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_FOLD |-> fold_idx_q == '0)
		else $error("head fold index left nonzero");

	a_fold_full_head: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FOLD |-> kept_count_q >= ibanm97_pkg::HEAD_COUNT)
		else $error("head folded before it was filled");

	a_clear_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (kept_count_q == '0 && rem_q == '0 && !error_seen_q &&
			state_q == ST_RUN && rsp_valid_q))
		else $error("candidate state not cleared after result");

endmodule

`default_nettype wire

// File: rtl/iban_mod97_checker_top.sv
// IBAN mod 97 checker, one character per req word, one result per candidate.
// req (valid/ready): char_code and last. rsp (valid/ready): iban_valid,
// too_short, bad_char, given once per word marked last.
// cfg_we/cfg_wdata: write min_length (reset value 15) while idle.
// A classifier feeds a four-entry queue; the back end drains one word a cycle
// while in its run state. After the word marked last it folds the buffered
// head (when at least four characters were kept), then loads the result
// register, and takes no new word until the result is loaded.
// Reset clears the queue, the candidate state and the result register;
// min_length returns to 15.
// A stalled rsp holds the result; the back end then waits in its final step,
// the queue fills and req_ready drops once four words are pending.
// Depends on ibanm97_pkg, ibanm97_front, ibanm97_queue, ibanm97_back.
`timescale 1ns / 1ps
`default_nettype none

module iban_mod97_checker_top #(
	parameter int unsigned MAX_KEPT = 32
) (
	input  var logic               clk,
	input  var logic               arst_n,
	input  var logic               cfg_we,
	input  var logic [5:0]         cfg_wdata,
	input  var logic               req_valid,
	output var logic               req_ready,
	input  var ibanm97_pkg::req_t  req,
	output var logic               rsp_valid,
	input  var logic               rsp_ready,
	output var ibanm97_pkg::rsp_t  rsp
);

	logic [5:0]          min_length_q;
	ibanm97_pkg::item_t  front_item;
	ibanm97_pkg::item_t  queue_item;
	logic                queue_valid;
	logic                queue_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= ibanm97_pkg::MIN_LENGTH_RESET;
		end else if (cfg_we) begin
			min_length_q <= cfg_wdata;
		end
	end

	ibanm97_front u_front (
		.req  (req),
		.item (front_item)
	);

	ibanm97_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (req_valid),
		.wr_ready (req_ready),
		.wr_item  (front_item),
		.rd_valid (queue_valid),
		.rd_ready (queue_ready),
		.rd_item  (queue_item)
	);

	ibanm97_back #(
		.MAX_KEPT (MAX_KEPT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.min_length (min_length_q),
		.item_valid (queue_valid),
		.item_ready (queue_ready),
		.item       (queue_item),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule

`default_nettype wire
